// ===== design/lgss_pkg.sv =====
// shared types and constants for the linear gradient span shader
`timescale 1ns / 1ps
package lgss_pkg;

    // stop table depth
    localparam int MAX_STOPS = 8;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_X      = 3'd0;
    localparam logic [2:0] REG_COEF_Y      = 3'd1;
    localparam logic [2:0] REG_COEF_OFFSET = 3'd2;
    localparam logic [2:0] REG_TILE_MODE   = 3'd3;
    localparam logic [2:0] REG_STOP_COUNT  = 3'd4;

    // tile modes
    localparam logic [1:0] TILE_CLAMP  = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    // opcodes
    localparam logic OP_WRITE_STOP = 1'b0;
    localparam logic OP_SHADE_SPAN = 1'b1;

    localparam logic [15:0] ONE_Q15 = 16'd32768;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // latch span coordinates
        logic mul;    // form coordinate products
        logic sum;    // form start accumulator
        logic emit;   // issue one pixel into the pipe
        logic last;   // issued pixel ends the span
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic adv;    // pipe advances this cycle
        logic busy;   // issue stage still holds a pixel
    } t_stat;

endpackage

// ===== design/lgss_ctrl.sv =====
// span sequencer: accepts items and issues one pixel per advancing cycle
`timescale 1ns / 1ps
module lgss_ctrl import lgss_pkg::*; #(
    parameter int MAX_SPAN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_opcode,
    input  logic [6:0]  i_span_length,
    input  t_stat       i_stat,
    output logic        o_idle,
    output t_cmd        o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic [6:0] len_sat;

    // saturate span length
    assign len_sat = (32'(i_span_length) > MAX_SPAN) ? 7'(MAX_SPAN) : i_span_length;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept && i_opcode == OP_SHADE_SPAN && len_sat != 7'd0) begin
                    n_state = ST_MUL;
                    n_cnt   = len_sat;
                end
            end
            ST_MUL: n_state = ST_SUM;
            ST_SUM: n_state = ST_RUN;
            ST_RUN: begin
                if (i_stat.adv) begin
                    n_cnt = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 7'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // commands
    assign o_idle     = (r_state == ST_IDLE) && !i_stat.busy;
    assign o_cmd.load = (r_state == ST_IDLE) && i_accept && i_opcode == OP_SHADE_SPAN;
    assign o_cmd.mul  = (r_state == ST_MUL);
    assign o_cmd.sum  = (r_state == ST_SUM);
    assign o_cmd.emit = (r_state == ST_RUN);
    assign o_cmd.last = (r_cnt == 7'd1);

endmodule

// ===== design/lgss_dp.sv =====
// datapath: config registers, stop table, parameter accumulator and shading pipe
`timescale 1ns / 1ps
module lgss_dp import lgss_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_wr,
    input  logic [11:0] i_start_x,
    input  logic [11:0] i_row_y,
    input  logic [2:0]  i_stop_index,
    input  logic [15:0] i_stop_alpha,
    input  logic [15:0] i_stop_red,
    input  logic [15:0] i_stop_green,
    input  logic [15:0] i_stop_blue,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_pixel,
    output logic        o_last_of_span
);

    localparam int SW = $clog2(MAX_STOPS);
    localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

    // configuration registers
    logic signed [31:0] r_cx, r_cy, r_co;
    logic [1:0]         r_tile;
    logic [3:0]         r_nstop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_co    <= '0;
            r_tile  <= TILE_CLAMP;
            r_nstop <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF_X:      r_cx    <= i_cfg_data;
                REG_COEF_Y:      r_cy    <= i_cfg_data;
                REG_COEF_OFFSET: r_co    <= i_cfg_data;
                REG_TILE_MODE:   r_tile  <= i_cfg_data[1:0];
                REG_STOP_COUNT:  r_nstop <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // stop table
    logic [63:0] mem [MAX_STOPS];
    logic [63:0] wdata;

    function automatic logic [15:0] sat15(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    assign wdata = {sat15(i_stop_alpha), sat15(i_stop_red),
                    sat15(i_stop_green), sat15(i_stop_blue)};

    always_ff @(posedge i_clk) begin
        if (i_wr && 32'(i_stop_index) < MAX_STOPS) begin
            mem[SW'(i_stop_index)] <= wdata;
        end
    end

    // pipe advance
    logic adv;
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic r_l0, r_l1, r_l2, r_l3, r_l4;

    assign adv         = !r_v4 || !i_out_stall;
    assign o_stat.adv  = adv;
    assign o_stat.busy = r_v0;

    // span setup and accumulator
    logic [11:0]        r_x, r_y;
    logic signed [45:0] r_px, r_py;
    logic signed [47:0] r_acc, r_s0;
    logic signed [47:0] px_e, py_e, co2, cx2;

    assign px_e = {{2{r_px[45]}}, r_px};
    assign py_e = {{2{r_py[45]}}, r_py};
    assign co2  = {{15{r_co[31]}}, r_co, 1'b0};
    assign cx2  = {{15{r_cx[31]}}, r_cx, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_start_x & CMASK;
            r_y <= i_row_y & CMASK;
        end
        if (i_cmd.mul) begin
            r_px <= r_cx * $signed({2'b00, r_x, 1'b1});
            r_py <= r_cy * $signed({2'b00, r_y, 1'b1});
        end
        if (i_cmd.sum) begin
            r_acc <= px_e + py_e + co2;
        end else if (i_cmd.emit && adv) begin
            r_acc <= r_acc + cx2;
        end
        if (adv) begin
            r_s0 <= r_acc;
        end
    end

    // tile and stop select
    logic signed [47:0] t;
    logic [16:0]        tt, u;
    logic [3:0]         n, nm1;
    logic [20:0]        d;
    logic [4:0]         idx, hidx;
    logic [15:0]        w;

    always_comb begin
        t = r_s0 >>> 1;
        u = t[16:0];
        unique case (r_tile)
            TILE_REPEAT: tt = {1'b0, t[15:0]};
            TILE_MIRROR: tt = (u < ONE_Q16) ? u : 17'(18'h20000 - {1'b0, u});
            default: begin
                if (t[47]) begin
                    tt = '0;
                end else if (t > 48'sd65536) begin
                    tt = ONE_Q16;
                end else begin
                    tt = t[16:0];
                end
            end
        endcase
        if (r_nstop == 4'd0) begin
            n = 4'd1;
        end else if (32'(r_nstop) > MAX_STOPS) begin
            n = 4'(MAX_STOPS);
        end else begin
            n = r_nstop;
        end
        nm1 = n - 4'd1;
        d   = tt * nm1;
        idx = d[20:16];
        w   = d[15:0];
        if (idx >= {1'b0, nm1}) begin
            idx = {1'b0, nm1};
            w   = '0;
        end
        hidx = (idx < {1'b0, nm1}) ? idx + 5'd1 : idx;
    end

    // stage 1: table read
    logic [63:0] r_lo, r_hi;
    logic [15:0] r_w;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lo <= mem[SW'(idx)];
            r_hi <= mem[SW'(hidx)];
            r_w  <= w;
        end
    end

    // stage 2: interpolate each channel to q1.23
    logic [23:0] r_ch [4];
    logic [32:0] c [4];
    logic [16:0] wi;

    assign wi = ONE_Q16 - {1'b0, r_w};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c[k] = ({17'd0, r_lo[63 - 16 * k -: 16]} * {16'd0, wi})
                   + ({17'd0, r_hi[63 - 16 * k -: 16]} * {17'd0, r_w})
                   + 33'd128;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                r_ch[k] <= c[k][31:8];
            end
        end
    end

    // stage 3: premultiply products and alpha byte
    logic [47:0] r_p [3];
    logic [7:0]  r_a3, r_a4;
    logic [32:0] asum;

    assign asum = ({9'd0, r_ch[0]} * 33'd255) + 33'h400000;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= r_ch[k + 1] * r_ch[0];
            end
            r_a3 <= asum[30:23];
        end
    end

    // stage 4: scale by 255 and round colour bytes
    logic [55:0] q [3];
    logic [7:0]  r_rgb [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q[k] = {r_p[k], 8'd0} - {8'd0, r_p[k]} + 56'h200000000000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_rgb[k] <= q[k][53:46];
            end
            r_a4 <= r_a3;
        end
    end

    // valid and last flags along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_cmd.emit;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l0 <= i_cmd.last;
            r_l1 <= r_l0;
            r_l2 <= r_l1;
            r_l3 <= r_l2;
            r_l4 <= r_l3;
        end
    end

    assign o_out_valid    = r_v4;
    assign o_pixel        = {r_a4, r_rgb[0], r_rgb[1], r_rgb[2]};
    assign o_last_of_span = r_l4;

endmodule

// ===== design/linear_gradient_span_shader_core.sv =====
// top level of the linear gradient span shader
`timescale 1ns / 1ps
// Usage:
//   Input channel i_valid / o_stall carries one item per transfer. Opcode
//   write stop loads one colour stop and gives no result; opcode shade span
//   gives span_length pixels, at most MAX_SPAN, the final one with
//   o_last_of_span set. Output channel o_valid / i_stall carries one pixel
//   per transfer. Config port i_cfg_valid / o_cfg_ready writes register
//   i_cfg_index with i_cfg_data; ready is always high, write only while
//   the block is idle.
// Sequencing:
//   a span passes two setup states (products, sum) and then issues one
//   pixel per cycle while the pipe advances, through a five stage shading
//   pipe. An item is accepted only when the sequencer is idle and the
//   issue stage is empty; the rate is set by the single pixel accumulator.
// Reset (synchronous, active low) clears control and the config registers;
//   the stop table is undefined until written.
// A stall on the output while a pixel is valid freezes the whole pipe; no pixel is lost.
module linear_gradient_span_shader_core import lgss_pkg::*; #(
    parameter int MAX_SPAN   = 64,
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [11:0] i_start_x,
    input  logic [11:0] i_row_y,
    input  logic [6:0]  i_span_length,
    input  logic [2:0]  i_stop_index,
    input  logic [15:0] i_stop_alpha,
    input  logic [15:0] i_stop_red,
    input  logic [15:0] i_stop_green,
    input  logic [15:0] i_stop_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel,
    output logic        o_last_of_span,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  idle, accept;

    assign o_stall     = !idle;
    assign accept      = i_valid && idle;
    assign o_cfg_ready = 1'b1;

    lgss_ctrl #(
        .MAX_SPAN(MAX_SPAN)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_span_length (i_span_length),
        .i_stat        (stat),
        .o_idle        (idle),
        .o_cmd         (cmd)
    );

    lgss_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_wr           (accept && i_opcode == OP_WRITE_STOP),
        .i_start_x      (i_start_x),
        .i_row_y        (i_row_y),
        .i_stop_index   (i_stop_index),
        .i_stop_alpha   (i_stop_alpha),
        .i_stop_red     (i_stop_red),
        .i_stop_green   (i_stop_green),
        .i_stop_blue    (i_stop_blue),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_pixel        (o_pixel),
        .o_last_of_span (o_last_of_span)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the linear gradient span shader core
`timescale 1ns / 1ps
module tb_top;
    import lgss_pkg::*;

    localparam int TIMEOUT_CYCLES = 600000;
    localparam int DRAIN_CYCLES   = 24;

    typedef struct {
        logic        opcode;
        logic [11:0] start_x;
        logic [11:0] row_y;
        logic [6:0]  span_length;
        logic [2:0]  stop_index;
        logic [15:0] alpha;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } shade_item_t;

    typedef struct {
        logic [31:0] pixel;
        logic        last;
    } pixel_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_opcode;
    logic [11:0] i_start_x;
    logic [11:0] i_row_y;
    logic [6:0]  i_span_length;
    logic [2:0]  i_stop_index;
    logic [15:0] i_stop_alpha;
    logic [15:0] i_stop_red;
    logic [15:0] i_stop_green;
    logic [15:0] i_stop_blue;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_pixel;
    logic        o_last_of_span;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    linear_gradient_span_shader_core dut (.*);

    // shadow copy of the block's registers and stop table
    longint signed grad_cx, grad_cy, grad_c0;
    logic [1:0]    grad_tile;
    logic [3:0]    grad_stops;
    logic [15:0]   stop_rgba [8][4];

    pixel_t pixel_q[$];
    int     mismatches;
    int     pixels_checked;
    int     spans_sent;
    int     cycle_count;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_off_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pixel_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // output stall: long hold-off has priority over random stalling
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // compute one premultiplied ARGB pixel from a Q16.16 parameter
    function automatic logic [31:0] shade_pixel(longint signed t);
        longint unsigned tt, u, d, w, c, a8;
        longint unsigned ch [4];
        longint unsigned r8 [3];
        int n, idx, hi_idx;
        n = (grad_stops == 0) ? 1 : (grad_stops > 8) ? 8 : grad_stops;
        if (grad_tile == TILE_REPEAT) begin
            tt = t[15:0];
        end else if (grad_tile == TILE_MIRROR) begin
            u = t[16:0];
            tt = (u < 65536) ? u : 131072 - u;
        end else begin
            tt = (t < 0) ? 0 : (t > 65536) ? 65536 : t;
        end
        d = tt * (n - 1);
        idx = int'(d >> 16);
        w = d & 16'hFFFF;
        if (idx >= n - 1) begin
            idx = n - 1;
            w = 0;
        end
        hi_idx = (idx + 1 < n) ? idx + 1 : idx;
        for (int k = 0; k < 4; k++) begin
            c = longint'(stop_rgba[idx][k]) * (65536 - w) + longint'(stop_rgba[hi_idx][k]) * w;
            ch[k] = (c + 128) >> 8;
        end
        a8 = (ch[0] * 255 + (64'd1 << 22)) >> 23;
        for (int k = 0; k < 3; k++)
            r8[k] = (ch[k + 1] * ch[0] * 255 + (64'd1 << 45)) >> 46;
        return {a8[7:0], r8[0][7:0], r8[1][7:0], r8[2][7:0]};
    endfunction

    // update the stop table or queue the pixels a span produces
    function automatic void predict_item(shade_item_t it);
        longint signed base, s;
        int len;
        pixel_t px;
        if (it.opcode == OP_WRITE_STOP) begin
            stop_rgba[it.stop_index][0] = (it.alpha > ONE_Q15) ? ONE_Q15 : it.alpha;
            stop_rgba[it.stop_index][1] = (it.red   > ONE_Q15) ? ONE_Q15 : it.red;
            stop_rgba[it.stop_index][2] = (it.green > ONE_Q15) ? ONE_Q15 : it.green;
            stop_rgba[it.stop_index][3] = (it.blue  > ONE_Q15) ? ONE_Q15 : it.blue;
            return;
        end
        len = (it.span_length > 64) ? 64 : int'(it.span_length);
        base = grad_cy * (2 * longint'(it.row_y) + 1) + 2 * grad_c0;
        for (int i = 0; i < len; i++) begin
            s = base + grad_cx * (2 * (longint'(it.start_x) + i) + 1);
            px.pixel = shade_pixel(s >>> 1);
            px.last = (i + 1 == len);
            pixel_q.insert(pixel_q.size(), px);
        end
        if (len > 0)
            spans_sent++;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h last %b", o_pixel, o_last_of_span);
            end else begin
                want = pixel_q.pop_front();
                pixels_checked++;
                if (want.pixel !== o_pixel || want.last !== o_last_of_span) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h last %b, got %h last %b",
                                 want.pixel, want.last, o_pixel, o_last_of_span);
                end
            end
        end
    end

    // one input transfer, with an optional idle gap first
    task automatic send_item(shade_item_t it);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= it.opcode;
        i_start_x     <= it.start_x;
        i_row_y       <= it.row_y;
        i_span_length <= it.span_length;
        i_stop_index  <= it.stop_index;
        i_stop_alpha  <= it.alpha;
        i_stop_red    <= it.red;
        i_stop_green  <= it.green;
        i_stop_blue   <= it.blue;
        do @(posedge i_clk); while (o_stall);
        predict_item(it);
    endtask

    task automatic send_stop(int idx, int a, int r, int g, int b);
        shade_item_t it;
        it = '{OP_WRITE_STOP, 12'($urandom), 12'($urandom), 7'($urandom), 3'(idx),
               16'(a), 16'(r), 16'(g), 16'(b)};
        send_item(it);
    endtask

    task automatic send_span(int x, int y, int len);
        shade_item_t it;
        it = '{OP_SHADE_SPAN, 12'(x), 12'(y), 7'(len), 3'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        send_item(it);
    endtask

    // let the block drain so config writes land while idle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COEF_X:      grad_cx = $signed(data);
            REG_COEF_Y:      grad_cy = $signed(data);
            REG_COEF_OFFSET: grad_c0 = $signed(data);
            REG_TILE_MODE:   grad_tile = data[1:0];
            REG_STOP_COUNT:  grad_stops = data[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_gradient(int cx, int cy, int c0, int tile, int stops);
        wait_idle();
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_Y, cy);
        write_reg(REG_COEF_OFFSET, c0);
        write_reg(REG_TILE_MODE, tile);
        write_reg(REG_STOP_COUNT, stops);
    endtask

    // every stop written before any span, extremes and saturating channels
    task automatic test_stop_load();
        send_stop(0, 0, 0, 0, 0);
        send_stop(1, 32768, 32768, 32768, 32768);
        send_stop(2, 65535, 65535, 40000, 32769);
        send_stop(3, 16384, 32768, 0, 8191);
        for (int i = 4; i < 8; i++)
            send_stop(i, $urandom_range(32768), $urandom_range(32768),
                      $urandom_range(32768), $urandom_range(32768));
    endtask

    // tile modes, stop count limits, span lengths and coordinate extremes
    task automatic test_directed_spans();
        set_gradient(32'sd16, 32'sd0, 32'sd0, TILE_CLAMP, 2);
        send_span(0, 0, 1);
        send_span(4095, 4095, 64);
        send_span(100, 7, 0);
        send_span(0, 1, 127);
        set_gradient(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, TILE_REPEAT, 8);
        send_span(4095, 0, 5);
        send_span(0, 4095, 5);
        set_gradient(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, TILE_MIRROR, 15);
        send_span(17, 4095, 6);
        set_gradient(32'sd300, -32'sd40, -32'sd65536, 3, 0);
        send_span(1000, 2000, 8);
        set_gradient(32'sd0, 32'sd0, 32'sd65536, TILE_CLAMP, 8);
        send_span(3, 3, 2);
        set_gradient(32'sd512, 32'sd256, 32'sd0, TILE_MIRROR, 1);
        send_span(200, 300, 12);
    endtask

    task automatic random_config();
        int cx, cy, c0;
        if ($urandom_range(3) == 0) begin
            cx = $urandom;
            cy = $urandom;
            c0 = $urandom;
        end else begin
            cx = $signed($urandom_range(4096)) - 2048;
            cy = $signed($urandom_range(1024)) - 512;
            c0 = $signed($urandom_range(262144)) - 131072;
        end
        set_gradient(cx, cy, c0, $urandom_range(3), $urandom_range(15));
    endtask

    // random spans, mostly short, with occasional stop rewrites
    task automatic test_random_phase(int idle_pct, int stall, int items);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        random_config();
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(9) == 0)
                send_stop($urandom_range(7), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(65535));
            else
                send_span($urandom, $urandom,
                          ($urandom_range(7) == 0) ? 64 : $urandom_range(16, 1));
        end
        wait_idle();
    endtask

    // hold the output off for a long stretch while spans keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        random_config();
        hold_off_left = 400;
        for (int i = 0; i < 6; i++)
            send_span($urandom, $urandom, 64);
        wait_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stall       <= 1'b0;
        i_opcode      <= OP_WRITE_STOP;
        i_start_x     <= '0;
        i_row_y       <= '0;
        i_span_length <= '0;
        i_stop_index  <= '0;
        i_stop_alpha  <= '0;
        i_stop_red    <= '0;
        i_stop_green  <= '0;
        i_stop_blue   <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        cycle_count = 0;
        mismatches = 0;
        pixels_checked = 0;
        spans_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_left = 0;
        grad_cx = 0;
        grad_cy = 0;
        grad_c0 = 0;
        grad_tile = TILE_CLAMP;
        grad_stops = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stop_load();
        test_directed_spans();
        test_random_phase(0, 0, 28);
        test_random_phase(78, 0, 25);
        test_random_phase(0, 78, 25);
        test_random_phase(6, 6, 28);
        test_backpressure();

        wait_idle();
        $display("checked %0d pixels from %0d spans over all tile modes and stop counts,",
                 pixels_checked, spans_sent);
        $display("with sender gaps, output stalls and a long output hold-off");
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d pixels missing", mismatches, pixel_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
